[hw/rtl/isbp_pkg.sv]
// shared types and constants for the i2c slave breathing pwm unit
package isbp_pkg;

  localparam int ADDR_W   = 8;
  localparam int BYTE_W   = 8;
  localparam int BITS_W   = 4;
  localparam int PWM_W    = 10;
  localparam int S_DATA_W = 8;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 32;

  localparam logic [ADDR_W-1:0] ADDR_RESET   = 8'h90;
  localparam logic [PWM_W-1:0]  PERIOD_RESET = 10'd1000;
  localparam logic [PWM_W-1:0]  DUTY_RESET   = 10'd1;

  // shift counts armed for the bit shifter
  localparam logic [BITS_W-1:0] BITS_NONE = 4'd0;
  localparam logic [BITS_W-1:0] BITS_ACK  = 4'd1;
  localparam logic [BITS_W-1:0] BITS_BYTE = 4'd8;

  localparam logic ACK_LVL  = 1'b0;
  localparam logic NACK_LVL = 1'b1;

  // item kinds
  localparam logic OP_BUS  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RX_ADDR  = 3'd1,
    PH_CHK_ADDR = 3'd2,
    PH_RELEASE  = 3'd3,
    PH_RX_DATA  = 3'd4,
    PH_CHK_DATA = 3'd5
  } phase_t;

  typedef struct packed {
    logic              op;
    logic              start_seen;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic              sda_drive;
    logic              ack_level;
    logic [BITS_W-1:0] bits_to_shift;
    logic              error_led;
  } bus_res_t;

  typedef struct packed {
    logic             tick;
    logic             period_load;
    logic [PWM_W-1:0] period_value;
  } pwm_ctl_t;

endpackage

[hw/rtl/isbp_in_reg.sv]
// input holding register for one bus event or timer tick
module isbp_in_reg import isbp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  logic  adv,
  input  item_t item_in,
  output logic  vld,
  output item_t item
);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= 1'b1;
    end else if (adv) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

endmodule

[hw/rtl/isbp_seq.sv]
// receive sequencer: bus phase, own address, ack, sda drive and error flag
module isbp_seq import isbp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  item_t             item,
  input  logic              cfg_wr,
  input  logic [ADDR_W-1:0] cfg_data,
  output bus_res_t          bus_res,
  output pwm_ctl_t          pwm_ctl
);

  phase_t            phase, phase_next, eff_phase;
  logic [ADDR_W-1:0] own_address, own_address_next;
  logic              drive_flag, drive_flag_next;
  logic              led_flag, led_flag_next;
  logic              addr_match;

  // a start condition forces the address-arm phase
  assign eff_phase  = (item.op == OP_BUS && item.start_seen) ? PH_RX_ADDR : phase;
  assign addr_match = (item.rx_byte == own_address);

  always_comb begin
    phase_next = phase;
    if (item.op == OP_BUS) begin
      unique case (eff_phase)
        PH_RX_ADDR:  phase_next = PH_CHK_ADDR;
        PH_CHK_ADDR: phase_next = addr_match ? PH_RX_DATA : PH_RELEASE;
        PH_RELEASE:  phase_next = PH_IDLE;
        PH_RX_DATA:  phase_next = PH_CHK_DATA;
        PH_CHK_DATA: phase_next = PH_RELEASE;
        default:     phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    bus_res.ack_level     = ACK_LVL;
    bus_res.bits_to_shift = BITS_NONE;
    drive_flag_next       = drive_flag;
    led_flag_next         = led_flag;
    own_address_next      = own_address;
    pwm_ctl.tick          = (item.op == OP_TICK);
    pwm_ctl.period_load   = 1'b0;
    pwm_ctl.period_value  = {item.rx_byte, 2'b00};
    if (item.op == OP_BUS) begin
      unique case (eff_phase)
        PH_RX_ADDR: begin
          bus_res.bits_to_shift = BITS_BYTE;
        end
        PH_CHK_ADDR: begin
          drive_flag_next       = 1'b1;
          bus_res.bits_to_shift = BITS_ACK;
          if (!addr_match) begin
            bus_res.ack_level = NACK_LVL;
            led_flag_next     = 1'b1;
          end
        end
        PH_RELEASE: begin
          drive_flag_next  = 1'b0;
          own_address_next = ADDR_RESET;
        end
        PH_RX_DATA: begin
          drive_flag_next       = 1'b0;
          bus_res.bits_to_shift = BITS_BYTE;
        end
        PH_CHK_DATA: begin
          drive_flag_next       = 1'b1;
          bus_res.bits_to_shift = BITS_ACK;
          pwm_ctl.period_load   = 1'b1;
        end
        default: ;
      endcase
    end
    bus_res.sda_drive = drive_flag_next;
    bus_res.error_led = led_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      own_address <= ADDR_RESET;
      drive_flag  <= 1'b0;
      led_flag    <= 1'b0;
    end else begin
      if (adv) begin
        phase      <= phase_next;
        drive_flag <= drive_flag_next;
        led_flag   <= led_flag_next;
      end
      if (cfg_wr) begin
        own_address <= cfg_data;
      end else if (adv) begin
        own_address <= own_address_next;
      end
    end
  end

  a_led_sticky: assert property (@(posedge clk) disable iff (rst)
    led_flag |=> led_flag)
    else $error("error flag cleared without reset");

  a_chk_addr_exit: assert property (@(posedge clk) disable iff (rst)
    (adv && item.op == OP_BUS && !item.start_seen && phase == PH_CHK_ADDR)
    |=> (phase == PH_RX_DATA || phase == PH_RELEASE))
    else $error("address check left to a wrong phase");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(phase))
    else $error("phase moved without an item");

endmodule

[hw/rtl/isbp_pwm.sv]
// pwm period register and up/down duty ramp
module isbp_pwm import isbp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  pwm_ctl_t         ctl,
  output logic [PWM_W-1:0] pwm_period,
  output logic [PWM_W-1:0] pwm_duty
);

  logic [PWM_W-1:0]      period, duty, duty_step;
  logic                  counting_down, counting_down_next;
  logic signed [PWM_W:0] top, duty_s;

  assign duty_step = counting_down ? duty - 1'b1 : duty + 1'b1;
  // period minus one as a signed value: a zero period gives -1
  assign top       = $signed({1'b0, period}) - $signed({{PWM_W{1'b0}}, 1'b1});
  assign duty_s    = $signed({1'b0, duty_step});

  always_comb begin
    counting_down_next = counting_down;
    if (ctl.tick) begin
      if (!counting_down && duty_s >= top) begin
        counting_down_next = 1'b1;
      end else if (counting_down && duty_s <= $signed({{PWM_W{1'b0}}, 1'b1})) begin
        counting_down_next = 1'b0;
      end
    end
  end

  assign pwm_period = ctl.period_load ? ctl.period_value : period;
  assign pwm_duty   = ctl.tick ? duty_step : duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      period        <= PERIOD_RESET;
      duty          <= DUTY_RESET;
      counting_down <= 1'b0;
    end else if (adv) begin
      period        <= pwm_period;
      duty          <= pwm_duty;
      counting_down <= counting_down_next;
    end
  end

  a_duty_by_one: assert property (@(posedge clk) disable iff (rst)
    (adv && ctl.tick) |=> (duty == $past(duty) + 1'b1 || duty == $past(duty) - 1'b1))
    else $error("duty moved by more than one step");

endmodule

[hw/rtl/i2c_slave_breathing_pwm_unit.sv]
// top level of the i2c slave receiver sequencer with breathing pwm duty
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata rx_byte, tuser {start_seen, op}
//  m_*       out  m_tvalid/m_tready  tdata packed result fields
//  cfg_*     in   cfg_valid/cfg_ready  own_address
//
//  one item per cycle sustained while m_tready keeps the result register draining; an
//  accepted item is held in the input register, is worked in one pass and lands in
//  the result register, from which its result is offered on m_tvalid/m_tdata
//  rst (synchronous) puts the phase to idle, period 1000, duty 1, address 0x90
//  a stalled result register holds the input register, which then backs up
//  s_tready; both stages are full at once, so no bubble under back-pressure
module i2c_slave_breathing_pwm_unit import isbp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] rx_byte
  input  logic [S_USER_W-1:0] s_tuser,   // [0] op, [1] start_seen
  output logic                m_tvalid,
  input  logic                m_tready,
  // [0] sda_drive, [1] ack_level, [5:2] bits_to_shift, [6] error_led,
  // [16:7] pwm_period, [26:17] pwm_duty, [31:27] zero
  output logic [M_DATA_W-1:0] m_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ADDR_W-1:0]   cfg_data
);

  item_t            item_in, item;
  logic             in_vld, adv, s_xfer;
  bus_res_t         bus_res, bus_q;
  pwm_ctl_t         pwm_ctl;
  logic [PWM_W-1:0] period_c, duty_c, period_q, duty_q;

  assign item_in.op         = s_tuser[0];
  assign item_in.start_seen = s_tuser[1];
  assign item_in.rx_byte    = s_tdata;

  // the held item moves on whenever the result register is free or draining
  assign adv      = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || adv;
  assign s_xfer   = s_tvalid && s_tready;

  // register writes are to be made only while idle; the block does not enforce it, so always ready
  assign cfg_ready = 1'b1;

  isbp_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (s_xfer),
    .adv     (adv),
    .item_in (item_in),
    .vld     (in_vld),
    .item    (item)
  );

  isbp_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .item     (item),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .bus_res  (bus_res),
    .pwm_ctl  (pwm_ctl)
  );

  isbp_pwm u_pwm (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .ctl        (pwm_ctl),
    .pwm_period (period_c),
    .pwm_duty   (duty_c)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bus_q    <= bus_res;
      period_q <= period_c;
      duty_q   <= duty_c;
    end
  end

  assign m_tdata = {5'b0, duty_q, period_q, bus_q.error_led, bus_q.bits_to_shift,
                    bus_q.ack_level, bus_q.sda_drive};

  // a nack is only ever sent in an ack slot
  a_nack_in_slot: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && bus_q.ack_level) |-> (bus_q.bits_to_shift == BITS_ACK))
    else $error("nack outside an acknowledge slot");

  // a full result register that is not taken blocks the held item
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !adv)
    else $error("result overwritten while stalled");

endmodule
